// ----- sv/dmbs_pkg.sv -----
// ============================================================================
// dmbs_pkg
// Shared types and constants of the digit scanner: LED command encoding,
// command bundle between scan logic and output serializer, register map.
// ============================================================================
package dmbs_pkg;

    typedef enum logic [1:0] {
        ACT_DISABLE = 2'd0,
        ACT_DRAW    = 2'd1,
        ACT_ENABLE  = 2'd2
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [2:0]  group_index;
        logic [7:0]  drawn_pattern;
    } t_cmd;

    typedef struct packed {
        logic [1:0]      cnt;
        t_cmd [2:0]      ent;
    } t_bundle;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBFIELD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_MODE     = 2'd2;

    localparam logic [3:0] DIGIT_COUNT_RST    = 4'd4;
    localparam logic [7:0] SUBFIELD_COUNT_RST = 8'd16;
    localparam logic [7:0] LEVEL_FULL         = 8'd255;

endpackage

// ----- sv/dmbs_table.sv -----
// ============================================================================
// dmbs_table
// Per-digit segment pattern and brightness store, one write port and one
// read port; entries never written read as blank and dark.
// ============================================================================
module dmbs_table #(
    parameter int MAX_DIGITS    = 8,
    parameter int SEGMENT_WIDTH = 8,
    parameter int IDX_W         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [IDX_W-1:0]         i_wr_idx,
    input  logic [SEGMENT_WIDTH-1:0] i_wr_pat,
    input  logic [7:0]               i_wr_lvl,
    input  logic [IDX_W-1:0]         i_rd_idx,
    output logic [SEGMENT_WIDTH-1:0] o_rd_pat,
    output logic [7:0]               o_rd_lvl
);
    logic [MAX_DIGITS-1:0]    r_vld;
    logic [SEGMENT_WIDTH-1:0] r_pat [MAX_DIGITS];
    logic [7:0]               r_lvl [MAX_DIGITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pat[i_wr_idx] <= i_wr_pat;
            r_lvl[i_wr_idx] <= i_wr_lvl;
        end
    end

    assign o_rd_pat = r_vld[i_rd_idx] ? r_pat[i_rd_idx] : '0;
    assign o_rd_lvl = r_vld[i_rd_idx] ? r_lvl[i_rd_idx] : '0;

endmodule

// ----- sv/dmbs_scan.sv -----
// ============================================================================
// dmbs_scan
// Scan state and single-pass tick evaluation: digit change, on-threshold,
// lit decision and up to three LED commands per tick as one bundle.
// ============================================================================
module dmbs_scan #(
    parameter int MAX_DIGITS    = 8,
    parameter int SEGMENT_WIDTH = 8,
    parameter int IDX_W         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  logic                     i_cmd,
    input  logic [2:0]               i_digit_index,
    input  logic [7:0]               i_segment_bits,
    input  logic [7:0]               i_level,
    input  logic [3:0]               i_digit_count,
    input  logic [7:0]               i_subfield_count,
    input  logic                     i_sleep_mode,
    input  logic                     i_bundle_ready,
    output logic                     o_consume,
    output logic                     o_load,
    output dmbs_pkg::t_bundle        o_bundle,
    output logic                     o_wr_en,
    output logic [IDX_W-1:0]         o_wr_idx,
    output logic [SEGMENT_WIDTH-1:0] o_wr_pat,
    output logic [7:0]               o_wr_lvl,
    output logic [IDX_W-1:0]         o_rd_idx,
    input  logic [SEGMENT_WIDTH-1:0] i_rd_pat,
    input  logic [7:0]               i_rd_lvl
);
    import dmbs_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [IDX_W-1:0]         r_cur;
    logic [IDX_W-1:0]         r_prev;
    logic [7:0]               r_sub;
    logic [7:0]               r_thr;
    logic                     r_prev_on;
    logic [SEGMENT_WIDTH-1:0] r_last;

    logic [IDX_W-1:0] cd;
    logic [IDX_W-1:0] n_cur;
    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] cd_inc;
    logic [15:0]      prod;
    logic [7:0]       thr;
    logic [8:0]       sub_inc;
    logic             changed;
    logic             lit0;
    logic             off;
    logic             draw;
    logic             wrap;
    logic             tick;
    logic             step;
    t_bundle          bundle;

    always_comb begin
        cd = r_cur;
        if (32'(r_cur) >= MAX_DIGITS) begin
            cd = '0;
        end
        changed = (cd != r_prev);
        prod    = {8'd0, i_subfield_count} * {8'd0, i_rd_lvl};
        thr     = changed ? prod[15:8] : r_thr;
        lit0    = changed ? 1'b0 : r_prev_on;
        off     = (i_rd_lvl != LEVEL_FULL) && (r_sub >= thr);
        draw    = !off && !lit0 && (i_rd_pat != r_last);

        bundle = '0;
        if (changed) begin
            bundle.ent[bundle.cnt] = '{ACT_DISABLE, 3'(r_prev), 8'd0};
            bundle.cnt             = bundle.cnt + 2'd1;
        end
        if (off && lit0) begin
            bundle.ent[bundle.cnt] = '{ACT_DISABLE, 3'(cd), 8'd0};
            bundle.cnt             = bundle.cnt + 2'd1;
        end
        if (draw) begin
            bundle.ent[bundle.cnt] = '{ACT_DRAW, 3'd0, 8'(i_rd_pat)};
            bundle.cnt             = bundle.cnt + 2'd1;
        end
        if (!off && !lit0) begin
            bundle.ent[bundle.cnt] = '{ACT_ENABLE, 3'(cd), 8'd0};
            bundle.cnt             = bundle.cnt + 2'd1;
        end

        if (i_digit_count == 4'd0) begin
            eff = CNT_W'(1);
        end else if (32'(i_digit_count) > MAX_DIGITS) begin
            eff = CNT_W'(MAX_DIGITS);
        end else begin
            eff = CNT_W'(i_digit_count);
        end
        cd_inc  = CNT_W'(cd) + CNT_W'(1);
        n_cur   = (cd_inc >= eff) ? '0 : IDX_W'(cd_inc);
        sub_inc = {1'b0, r_sub} + 9'd1;
        wrap    = (sub_inc >= {1'b0, i_subfield_count});

        tick      = i_item_valid && !i_cmd && !i_sleep_mode;
        o_consume = i_item_valid && (!tick || bundle.cnt == 2'd0 || i_bundle_ready);
        step      = tick && o_consume;
        o_load    = step && (bundle.cnt != 2'd0);
    end

    assign o_bundle = bundle;
    assign o_rd_idx = cd;
    assign o_wr_en  = i_item_valid && i_cmd && (32'(i_digit_index) < MAX_DIGITS);
    assign o_wr_idx = IDX_W'(i_digit_index);
    assign o_wr_pat = SEGMENT_WIDTH'(i_segment_bits);
    assign o_wr_lvl = i_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_prev    <= '0;
            r_sub     <= '0;
            r_thr     <= '0;
            r_prev_on <= 1'b0;
            r_last    <= '0;
        end else if (step) begin
            r_cur     <= wrap ? n_cur : cd;
            r_sub     <= wrap ? 8'd0 : sub_inc[7:0];
            r_prev    <= cd;
            r_prev_on <= !off;
            if (changed) begin
                r_thr <= prod[15:8];
            end
            if (draw) begin
                r_last <= i_rd_pat;
            end
        end
    end

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < MAX_DIGITS)
        else $error("current digit out of range");

    a_change_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && changed) |-> (bundle.ent[0].action == ACT_DISABLE
                                 && bundle.ent[0].group_index == 3'(r_prev)))
        else $error("digit change without disable of previous digit");

endmodule

// ----- sv/dmbs_out.sv -----
// ============================================================================
// dmbs_out
// Command bundle register and serializer: presents the commands of one tick
// one per transaction, marking the final one with tlast.
// ============================================================================
module dmbs_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dmbs_pkg::t_bundle i_bundle,
    output logic              o_bundle_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,  // group_index[2:0], drawn_pattern[10:3]
    output logic [1:0]        m_axis_tuser,  // action[1:0]
    output logic              m_axis_tlast
);
    import dmbs_pkg::*;

    logic [1:0]  r_cnt;
    t_cmd [2:0]  r_ent;
    logic        take;

    assign take           = (r_cnt != 2'd0) && m_axis_tready;
    assign o_bundle_ready = (r_cnt == 2'd0) || (m_axis_tready && r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_bundle.ent;
        end else if (take) begin
            r_ent[0] <= r_ent[1];
            r_ent[1] <= r_ent[2];
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = r_ent[0].action;
    assign m_axis_tdata  = {5'd0, r_ent[0].drawn_pattern, r_ent[0].group_index};
    assign m_axis_tlast  = (r_cnt == 2'd1);

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_bundle_ready)
        else $error("bundle loaded over pending commands");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt != 2'd0))
        else $error("empty bundle loaded");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !i_load) |=> !m_axis_tvalid)
        else $error("commands left after final transaction");

endmodule

// ----- sv/digit_mux_brightness_scanner_core.sv -----
// ============================================================================
// digit_mux_brightness_scanner_core
// Multiplexed LED digit scanner with per-digit brightness by subfield
// modulation, emitting LED-matrix commands per scan tick.
// ============================================================================
// An item passes an input register, is evaluated against the digit table and
// scan state, and its commands (up to three) land in an output bundle register
// that sends them one per transaction. Table writes, ticks while asleep and
// ticks that cause no command never wait for the output. A tick with commands
// waits until the bundle register is free or its last command is being taken,
// so the output serializer limits the tick rate; the next tick is evaluated
// while the last command of the previous one is taken. An input transaction
// reaches the command output through the input and output bundle registers.
module digit_mux_brightness_scanner_core #(
    parameter int MAX_DIGITS    = 8,
    parameter int SEGMENT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // digit_index[2:0], segment_bits[10:3], level[18:11]
    input  logic        s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // group_index[2:0], drawn_pattern[10:3]
    output logic [1:0]  m_axis_tuser,   // action[1:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dmbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dmbs_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic       r_in_v;
    logic       r_cmd;
    logic [2:0] r_idx;
    logic [7:0] r_seg;
    logic [7:0] r_lvl;
    logic [3:0] r_digit_count;
    logic [7:0] r_subfield_count;
    logic       r_sleep_mode;

    logic                     consume;
    logic                     load;
    logic                     bundle_ready;
    t_bundle                  bundle;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic [SEGMENT_WIDTH-1:0] wr_pat;
    logic [7:0]               wr_lvl;
    logic [IDX_W-1:0]         rd_idx;
    logic [SEGMENT_WIDTH-1:0] rd_pat;
    logic [7:0]               rd_lvl;

    assign s_axis_tready = !r_in_v || consume;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_v <= 1'b1;
        end else if (consume) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser;
            r_idx <= s_axis_tdata[2:0];
            r_seg <= s_axis_tdata[10:3];
            r_lvl <= s_axis_tdata[18:11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count    <= DIGIT_COUNT_RST;
            r_subfield_count <= SUBFIELD_COUNT_RST;
            r_sleep_mode     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIGIT_COUNT: begin
                    r_digit_count <= i_cfg_data[3:0];
                end
                CFG_SUBFIELD_COUNT: begin
                    r_subfield_count <= i_cfg_data;
                end
                CFG_SLEEP_MODE: begin
                    r_sleep_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    dmbs_table #(
        .MAX_DIGITS    (MAX_DIGITS),
        .SEGMENT_WIDTH (SEGMENT_WIDTH),
        .IDX_W         (IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr_pat (wr_pat),
        .i_wr_lvl (wr_lvl),
        .i_rd_idx (rd_idx),
        .o_rd_pat (rd_pat),
        .o_rd_lvl (rd_lvl)
    );

    dmbs_scan #(
        .MAX_DIGITS    (MAX_DIGITS),
        .SEGMENT_WIDTH (SEGMENT_WIDTH),
        .IDX_W         (IDX_W)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (r_in_v),
        .i_cmd            (r_cmd),
        .i_digit_index    (r_idx),
        .i_segment_bits   (r_seg),
        .i_level          (r_lvl),
        .i_digit_count    (r_digit_count),
        .i_subfield_count (r_subfield_count),
        .i_sleep_mode     (r_sleep_mode),
        .i_bundle_ready   (bundle_ready),
        .o_consume        (consume),
        .o_load           (load),
        .o_bundle         (bundle),
        .o_wr_en          (wr_en),
        .o_wr_idx         (wr_idx),
        .o_wr_pat         (wr_pat),
        .o_wr_lvl         (wr_lvl),
        .o_rd_idx         (rd_idx),
        .i_rd_pat         (rd_pat),
        .i_rd_lvl         (rd_lvl)
    );

    dmbs_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_bundle       (bundle),
        .o_bundle_ready (bundle_ready),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

endmodule

// ----- test/tb_digit_mux_brightness_scanner_core.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_digit_mux_brightness_scanner_core
// Self-checking bench for the digit scanner. A short table of directed
// transactions and register writes is followed by random phases, each with
// its own register setting. Every accepted table write and tick runs through
// a local scan model, and each LED command leaving the block is compared
// field by field with the oldest predicted one. Both stream sides idle at
// random, and one phase holds the command side off long enough to back up
// the input.
// ============================================================================
module tb_digit_mux_brightness_scanner_core;
    import dmbs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_ITEMS   = 70;
    localparam int PHASE_ITEMS  = 20;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 80;
    localparam int N_DIR        = 35;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } scan_cmd_e;

    typedef struct packed {
        t_action    act;
        logic [2:0] grp;
        logic [7:0] pat;
        logic       last;
    } led_cmd_t;

    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [7:0]           reg_val;
        scan_cmd_e            cmd;
        logic [2:0]           idx;
        logic [7:0]           seg;
        logic [7:0]           lvl;
        logic                 typed;
        logic [1:0]           n_typed;
        led_cmd_t [2:0]       typed_res;
    } dir_row_t;

    localparam led_cmd_t NO_CMD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // digit_index[2:0], segment_bits[10:3], level[18:11]
    logic        s_axis_tuser = 1'b0; // cmd[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // group_index[2:0], drawn_pattern[10:3]
    logic [1:0]  m_axis_tuser;        // action[1:0]
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    digit_mux_brightness_scanner_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // scan model state
    logic [7:0] tbl_pat [8];
    logic [7:0] tbl_lvl [8];
    logic [2:0] cur_dig;
    logic [2:0] prev_dig;
    logic [8:0] sub_cnt;
    logic [7:0] on_thr;
    logic       prev_lit;
    logic [7:0] last_pat;
    logic [3:0] cfg_digits;
    logic [7:0] cfg_subfields;
    logic       cfg_sleep;

    led_cmd_t expected_cmds [$];
    int  mismatches = 0;
    int  n_results = 0;
    int  n_ticks = 0;
    int  n_writes = 0;
    int  n_reg_writes = 0;
    int  cycle_cnt = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;

    function automatic led_cmd_t led_cmd(t_action act, logic [2:0] grp, logic [7:0] pat,
                                         logic last);
        return '{act: act, grp: grp, pat: pat, last: last};
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        dir_row_t r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t item_row(scan_cmd_e cmd, logic [2:0] idx, logic [7:0] seg,
                                          logic [7:0] lvl);
        dir_row_t r;
        r = '0;
        r.cmd = cmd;
        r.idx = idx;
        r.seg = seg;
        r.lvl = lvl;
        return r;
    endfunction

    function automatic dir_row_t typed_row(scan_cmd_e cmd, logic [2:0] idx, logic [7:0] seg,
                                           logic [7:0] lvl, logic [1:0] n, led_cmd_t r0,
                                           led_cmd_t r1);
        dir_row_t r;
        r = item_row(cmd, idx, seg, lvl);
        r.typed        = 1'b1;
        r.n_typed      = n;
        r.typed_res[0] = r0;
        r.typed_res[1] = r1;
        return r;
    endfunction

    function automatic int scan_predict(dir_row_t it, output led_cmd_t [2:0] res);
        int         n;
        int         eff;
        logic [2:0] cd;
        logic [7:0] lvl;
        logic [7:0] pat;
        logic       lit;
        logic [15:0] prod;
        n   = 0;
        res = '0;
        if (it.cmd == CMD_WRITE) begin
            tbl_pat[it.idx] = it.seg;
            tbl_lvl[it.idx] = it.lvl;
            return 0;
        end
        if (cfg_sleep) return 0;
        eff = (cfg_digits == 0) ? 1 : ((cfg_digits > 8) ? 8 : int'(cfg_digits));
        cd  = cur_dig;
        lvl = tbl_lvl[cd];
        pat = tbl_pat[cd];
        if (cd != prev_dig) begin
            res[n] = led_cmd(ACT_DISABLE, prev_dig, 8'd0, 1'b0);
            n++;
            lit    = 1'b0;
            prod   = 16'(cfg_subfields) * 16'(lvl);
            on_thr = prod[15:8];
        end else begin
            lit = prev_lit;
        end
        if (lvl != LEVEL_FULL && sub_cnt >= {1'b0, on_thr}) begin
            if (lit) begin
                res[n] = led_cmd(ACT_DISABLE, cd, 8'd0, 1'b0);
                n++;
                lit = 1'b0;
            end
        end else if (!lit) begin
            if (pat != last_pat) begin
                res[n] = led_cmd(ACT_DRAW, 3'd0, pat, 1'b0);
                n++;
                last_pat = pat;
            end
            res[n] = led_cmd(ACT_ENABLE, cd, 8'd0, 1'b0);
            n++;
            lit = 1'b1;
        end
        sub_cnt  = sub_cnt + 9'd1;
        prev_dig = cd;
        prev_lit = lit;
        if (sub_cnt >= {1'b0, cfg_subfields}) begin
            cd      = (int'(cd) + 1 >= eff) ? 3'd0 : cd + 3'd1;
            sub_cnt = '0;
        end
        cur_dig = cd;
        if (n > 0) res[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic send_item(input dir_row_t it);
        int             gap;
        int             n;
        int             k;
        led_cmd_t [2:0] res;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {5'd0, it.lvl, it.seg, it.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        n = scan_predict(it, res);
        if (it.typed) begin
            n   = it.n_typed;
            res = it.typed_res;
        end
        for (k = 0; k < n; k++) expected_cmds.push_back(res[k]);
        if (it.cmd == CMD_WRITE) n_writes++;
        else n_ticks++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        s_axis_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DIGIT_COUNT:    cfg_digits = val[3:0];
            CFG_SUBFIELD_COUNT: cfg_subfields = val;
            CFG_SLEEP_MODE:     cfg_sleep = val[0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding", cycle_cnt,
                     expected_cmds.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // command side: random stalls plus one long hold-off
    initial begin : cmd_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) stall_left = no_idle ? 0 : $urandom_range(0, 6);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : cmd_check
        led_cmd_t got;
        led_cmd_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = led_cmd(t_action'(m_axis_tuser), m_axis_tdata[2:0], m_axis_tdata[10:3],
                          m_axis_tlast);
            n_results++;
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected command act=%0d grp=%0d pat=%02h last=%0b",
                             got.act, got.grp, got.pat, got.last);
            end else begin
                want = expected_cmds.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: command %0d expected act=%0d grp=%0d pat=%02h last=%0b",
                                 n_results, want.act, want.grp, want.pat, want.last);
                        $display("       got act=%0d grp=%0d pat=%02h last=%0b",
                                 got.act, got.grp, got.pat, got.last);
                    end
                end
            end
        end
    end

    initial begin
        dir_row_t  dir_rows [N_DIR];
        dir_row_t  it;
        int        k;
        int        phase;
        int        rand_count;
        logic [7:0] dc;
        logic [7:0] sf;
        logic [7:0] sl;

        for (k = 0; k < 8; k++) begin
            tbl_pat[k] = '0;
            tbl_lvl[k] = '0;
        end
        cur_dig       = '0;
        prev_dig      = '0;
        sub_cnt       = '0;
        on_thr        = '0;
        prev_lit      = 1'b0;
        last_pat      = '0;
        cfg_digits    = DIGIT_COUNT_RST;
        cfg_subfields = SUBFIELD_COUNT_RST;
        cfg_sleep     = 1'b0;

        dir_rows = '{
            typed_row(CMD_TICK,  3'd0, 8'h00, 8'h00, 2'd0, NO_CMD, NO_CMD),
            typed_row(CMD_WRITE, 3'd0, 8'hFF, 8'hFF, 2'd0, NO_CMD, NO_CMD),
            typed_row(CMD_TICK,  3'd0, 8'h00, 8'h00, 2'd2,
                      led_cmd(ACT_DRAW, 3'd0, 8'hFF, 1'b0),
                      led_cmd(ACT_ENABLE, 3'd0, 8'h00, 1'b1)),
            typed_row(CMD_TICK,  3'd7, 8'hFF, 8'hFF, 2'd0, NO_CMD, NO_CMD),
            typed_row(CMD_WRITE, 3'd1, 8'h00, 8'h00, 2'd0, NO_CMD, NO_CMD),
            reg_row(CFG_SUBFIELD_COUNT, 8'd1),
            typed_row(CMD_TICK,  3'd0, 8'h00, 8'h00, 2'd0, NO_CMD, NO_CMD),
            typed_row(CMD_TICK,  3'd0, 8'h00, 8'h00, 2'd1,
                      led_cmd(ACT_DISABLE, 3'd0, 8'h00, 1'b1), NO_CMD),
            item_row(CMD_WRITE, 3'd2, 8'h80, 8'h7F),
            item_row(CMD_TICK,  3'd5, 8'h5A, 8'hA5),
            reg_row(CFG_DIGIT_COUNT, 8'd8),
            item_row(CMD_WRITE, 3'd7, 8'h01, 8'hFE),
            item_row(CMD_WRITE, 3'd3, 8'hAA, 8'h80),
            reg_row(CFG_SUBFIELD_COUNT, 8'd0),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            reg_row(CFG_SUBFIELD_COUNT, 8'd255),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            reg_row(CFG_DIGIT_COUNT, 8'd0),
            reg_row(CFG_SUBFIELD_COUNT, 8'd2),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            reg_row(CFG_DIGIT_COUNT, 8'd15),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            reg_row(CFG_SLEEP_MODE, 8'd1),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            item_row(CMD_WRITE, 3'd4, 8'h3C, 8'hFF),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            reg_row(CFG_SLEEP_MODE, 8'd0),
            item_row(CMD_TICK,  3'd0, 8'h00, 8'h00),
            reg_row(CFG_UNUSED, 8'hFF)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].is_reg) write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            else send_item(dir_rows[k]);
        end

        phase      = 0;
        rand_count = 0;
        while (rand_count < RAND_ITEMS) begin
            dc = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 15));
            case ($urandom_range(0, 7))
                0:       sf = 8'd0;
                1:       sf = 8'd255;
                default: sf = 8'($urandom_range(1, 6));
            endcase
            sl    = 8'($urandom_range(0, 255));
            sl[0] = (phase > 2) && ($urandom_range(0, 3) == 0);
            write_reg(CFG_DIGIT_COUNT, dc);
            write_reg(CFG_SUBFIELD_COUNT, sf);
            write_reg(CFG_SLEEP_MODE, sl);
            no_idle = (phase == 2) || ($urandom_range(0, 4) == 0);
            if (phase == 1) hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                it = item_row(($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_TICK,
                              3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                if (it.cmd == CMD_WRITE) begin
                    case ($urandom_range(0, 3))
                        0:       it.lvl = LEVEL_FULL;
                        1:       it.lvl = 8'd0;
                        default: ;
                    endcase
                end
                send_item(it);
                if (!(it.cmd == CMD_TICK && cfg_sleep)) rand_count++;
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d ticks and %0d table writes, %0d register writes, %0d settings",
                 n_ticks, n_writes, n_reg_writes, phase + 1);
        $display("checked %0d LED commands, %0d mismatches", n_results, mismatches);
        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/dmbs_pkg.sv
sv/dmbs_table.sv
sv/dmbs_scan.sv
sv/dmbs_out.sv
sv/digit_mux_brightness_scanner_core.sv
test/tb_digit_mux_brightness_scanner_core.sv
